[design/twma_pkg.sv]
// Shared types, constants and codes for the time window motion accumulator.
`default_nettype none
package twma_pkg;

  localparam int TIME_W   = 64;
  localparam int DELTA_W  = 20;
  localparam int SUM_W    = 26;
  localparam int COUNT_W  = 7;
  localparam int WINDOW_W = 32;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam int RING_DEPTH_DEF = 64;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(10000000);

  // Item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Register word index (paddr[2])
  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PURGE,
    S_EVICT,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]         t;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } ring_entry_t;

  typedef struct packed {
    logic latch;     // capture the accepted item and its cutoff
    logic drop;      // pop the oldest entry
    logic write;     // append the latched sample
    logic load_out;  // move the sums into the output register
  } twma_cmd_t;

  typedef struct packed {
    logic op_tick;
    logic empty;
    logic last;
    logic full;
    logic expired;
    logic out_busy;
  } twma_status_t;

endpackage
`default_nettype wire

[design/twma_item_if.sv]
// Input channel: one item beat (sample or tick).
`default_nettype none
interface twma_item_if;
  import twma_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [TIME_W-1:0]         event_time;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;

  modport source (output valid, op, event_time, delta_x, delta_y, input ready);
  modport sink   (input valid, op, event_time, delta_x, delta_y, output ready);
endinterface
`default_nettype wire

[design/twma_result_if.sv]
// Output channel: one result beat with both window sums and the entry count.
`default_nettype none
interface twma_result_if;
  import twma_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] window_sum_x;
  logic signed [SUM_W-1:0] window_sum_y;
  logic [COUNT_W-1:0]      entry_count;

  modport source (output valid, window_sum_x, window_sum_y, entry_count, input ready);
  modport sink   (input valid, window_sum_x, window_sum_y, entry_count, output ready);
endinterface
`default_nettype wire

[design/twma_cfg.sv]
// APB register block holding the window length.
`default_nettype none
module twma_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [twma_pkg::APB_AW-1:0]    paddr,
  input  wire logic [twma_pkg::APB_DW-1:0]    pwdata,
  output logic      [twma_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  output logic      [twma_pkg::WINDOW_W-1:0]  window
);
  import twma_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Update the window on a completed write to its word
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (wr_en && paddr[2] == REG_WINDOW) begin
      window <= pwdata[WINDOW_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW) begin
      prdata = APB_DW'(window);
    end
  end

endmodule
`default_nettype wire

[design/twma_ctrl.sv]
// Sequencer for append, evict and purge passes over the ring.
`default_nettype none
module twma_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  input  wire logic                   item_op,
  output logic                        item_ready,
  input  wire twma_pkg::twma_status_t st,
  output twma_pkg::twma_cmd_t         cmd
);
  import twma_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.latch = 1'b1;
          if (item_op == OP_TICK) begin
            state_next = st.empty ? S_DONE : S_READ;
          end else begin
            state_next = st.full ? S_READ : S_WRITE;
          end
        end
      end
      // Oldest entry lands in the read register
      S_READ: begin
        state_next = st.op_tick ? S_PURGE : S_EVICT;
      end
      // Pop while the oldest entry is older than the cutoff
      S_PURGE: begin
        if (st.expired) begin
          cmd.drop   = 1'b1;
          state_next = st.last ? S_DONE : S_PURGE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_EVICT: begin
        cmd.drop   = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_DONE;
      end
      // Hand the sums to the output register once it is free
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_purge_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_PURGE |-> !st.empty)
    else $error("purge pass on an empty ring");
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    state == S_EVICT |-> st.full)
    else $error("eviction with free room in the ring");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !st.out_busy)
    else $error("result loaded over a waiting beat");

endmodule
`default_nettype wire

[design/twma_dp.sv]
// Ring memory, running sums, cutoff compare and output register.
`default_nettype none
module twma_dp #(
  parameter int RING_DEPTH = twma_pkg::RING_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [twma_pkg::WINDOW_W-1:0]       window,
  input  wire logic                                item_op,
  input  wire logic [twma_pkg::TIME_W-1:0]         item_time,
  input  wire logic signed [twma_pkg::DELTA_W-1:0] item_dx,
  input  wire logic signed [twma_pkg::DELTA_W-1:0] item_dy,
  input  wire twma_pkg::twma_cmd_t                 cmd,
  output twma_pkg::twma_status_t                   st,
  twma_result_if.source                            result
);
  import twma_pkg::*;

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  ring_entry_t mem [RING_DEPTH];
  ring_entry_t rd_entry;

  logic                      op_q;
  logic [TIME_W-1:0]         time_q;
  logic signed [DELTA_W-1:0] dx_q;
  logic signed [DELTA_W-1:0] dy_q;
  logic [TIME_W-1:0]         cutoff;
  logic [IW-1:0]             oldest;
  logic [CW-1:0]             count;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic                      res_valid;

  logic [IW-1:0]             oldest_inc;
  logic [IW:0]               tail_sum;
  logic [IW:0]               tail_wrap;
  logic [IW-1:0]             tail;
  logic [IW-1:0]             rd_addr;
  logic [TIME_W:0]           diff;
  logic [CW+COUNT_W-1:0]     cnt_ext;
  logic signed [SUM_W-1:0]   add_x, add_y, sub_x, sub_y;

  // Ring pointer arithmetic
  assign oldest_inc = (oldest == IW'(RING_DEPTH - 1)) ? '0 : oldest + 1'b1;
  assign tail_sum   = {1'b0, oldest} + (IW+1)'(count);
  assign tail_wrap  = (tail_sum >= (IW+1)'(RING_DEPTH)) ?
                      tail_sum - (IW+1)'(RING_DEPTH) : tail_sum;
  assign tail       = tail_wrap[IW-1:0];
  assign rd_addr    = cmd.drop ? oldest_inc : oldest;

  // Saturating cutoff: now - window, clamped at zero
  assign diff = {1'b0, item_time} - {{(TIME_W + 1 - WINDOW_W){1'b0}}, window};

  assign add_x = SUM_W'(dx_q);
  assign add_y = SUM_W'(dy_q);
  assign sub_x = SUM_W'(rd_entry.dx);
  assign sub_y = SUM_W'(rd_entry.dy);

  assign cnt_ext = {{COUNT_W{1'b0}}, count};

  // Ring memory: write the tail, read the oldest (or the next after a pop)
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[tail] <= '{t: time_q, dx: dx_q, dy: dy_q};
    end
    rd_entry <= mem[rd_addr];
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= item_op;
      time_q <= item_time;
      dx_q   <= item_dx;
      dy_q   <= item_dy;
      cutoff <= diff[TIME_W] ? '0 : diff[TIME_W-1:0];
    end
  end

  // Pointer, count and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
    end else if (cmd.drop) begin
      oldest <= oldest_inc;
      count  <= count - 1'b1;
      if (count == CW'(1)) begin
        sum_x <= '0;
        sum_y <= '0;
      end else begin
        sum_x <= sum_x - sub_x;
        sum_y <= sum_y - sub_y;
      end
    end else if (cmd.write) begin
      count <= count + 1'b1;
      sum_x <= sum_x + add_x;
      sum_y <= sum_y + add_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.window_sum_x <= sum_x;
      result.window_sum_y <= sum_y;
      result.entry_count  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign result.valid = res_valid;

  // Status to the sequencer
  assign st.op_tick  = (op_q == OP_TICK);
  assign st.empty    = (count == '0);
  assign st.last     = (count == CW'(1));
  assign st.full     = (count == CW'(RING_DEPTH));
  assign st.expired  = (rd_entry.t < cutoff);
  assign st.out_busy = res_valid && !result.ready;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(RING_DEPTH))
    else $error("entry count beyond ring depth");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> sum_x == '0 && sum_y == '0)
    else $error("nonzero sums on an empty ring");
  a_drop_held: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> count != '0)
    else $error("pop from an empty ring");
  a_write_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> count == $past(count) + 1'b1)
    else $error("append did not grow the count");

endmodule
`default_nettype wire

[design/time_window_motion_accumulator_unit.sv]
// Top level of the time window motion accumulator.
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------
//  item     | in  | op, event_time, delta_x, delta_y
//  result   | out | window_sum_x, window_sum_y, entry_count
//  apb      | in  | window_ns at word 0 (paddr 0)
//
// A sample on a full ring evicts the oldest entry first; a tick on an empty
// ring skips the purge pass and goes straight to the result.
// The purge loop pops one entry per cycle through the single read port of the
// ring memory.
// Reset clears the pointer, count and sums; the ring contents are not cleared.
// One item is in work at a time; the next is taken while a result waits in
// the output register, and the sequencer holds only if that register is full.
`default_nettype none
module time_window_motion_accumulator_unit #(
  parameter int RING_DEPTH = twma_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  twma_item_if.sink                          item,
  twma_result_if.source                      result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [twma_pkg::APB_AW-1:0]   paddr,
  input  wire logic [twma_pkg::APB_DW-1:0]   pwdata,
  output logic      [twma_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);
  import twma_pkg::*;

  logic [WINDOW_W-1:0] window;
  twma_cmd_t           cmd;
  twma_status_t        st;
  logic                item_ready;

  assign item.ready = item_ready;

  twma_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  twma_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_op    (item.op),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  twma_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .window    (window),
    .item_op   (item.op),
    .item_time (item.event_time),
    .item_dx   (item.delta_x),
    .item_dy   (item.delta_y),
    .cmd       (cmd),
    .st        (st),
    .result    (result)
  );

endmodule
`default_nettype wire

[tb/twma_window_checker.sv]
// Checker for the motion accumulator: watches both channels and the APB port, predicts and compares.
`timescale 1ns / 100ps
module twma_window_checker
  import twma_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  twma_item_if              item_bus,
  twma_result_if            result_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                results_owed
);

  localparam int MAX_SHOWN = 200;

  typedef struct packed {
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [COUNT_W-1:0] count;
  } window_totals_t;

  // Shadow of the ring, its pointers and the running sums
  ring_entry_t         slots [RING_DEPTH];
  int unsigned         head;
  int unsigned         held;
  logic [SUM_W-1:0]    acc_x;
  logic [SUM_W-1:0]    acc_y;
  logic [WINDOW_W-1:0] window_len;
  window_totals_t      expected_totals_q [$];
  int                  err_total = 0;
  int                  shown = 0;

  function automatic logic [SUM_W-1:0] widen(logic signed [DELTA_W-1:0] d);
    return {{(SUM_W-DELTA_W){d[DELTA_W-1]}}, d};
  endfunction

  // Pop the oldest held sample and take its delta out of the sums
  function automatic void expire_oldest();
    acc_x = acc_x - widen(slots[head].dx);
    acc_y = acc_y - widen(slots[head].dy);
    head  = (head + 1 == RING_DEPTH) ? 0 : head + 1;
    held--;
    // an empty ring always reads back exact zero sums
    if (held == 0) begin
      acc_x = '0;
      acc_y = '0;
    end
  endfunction

  // Apply one item beat to the shadow state and return the totals it reports
  function automatic window_totals_t next_window_totals(logic op, logic [TIME_W-1:0] t,
                                                        logic signed [DELTA_W-1:0] dx,
                                                        logic signed [DELTA_W-1:0] dy);
    logic [TIME_W-1:0] cutoff;
    int unsigned       slot;
    window_totals_t    totals;
    if (op == OP_TICK) begin
      // cutoff saturates at zero when now is inside the first window
      cutoff = (t < TIME_W'(window_len)) ? '0 : t - TIME_W'(window_len);
      while (held > 0 && slots[head].t < cutoff) expire_oldest();
    end else begin
      // evict first on a full ring
      if (held >= RING_DEPTH) expire_oldest();
      slot = head + held;
      if (slot >= RING_DEPTH) slot -= RING_DEPTH;
      slots[slot] = '{t: t, dx: dx, dy: dy};
      held++;
      acc_x = acc_x + widen(dx);
      acc_y = acc_y + widen(dy);
    end
    totals.sum_x = acc_x;
    totals.sum_y = acc_y;
    totals.count = COUNT_W'(held);
    return totals;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_total++;
      if (shown < MAX_SHOWN) begin
        shown++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    window_totals_t want;
    if (rst) begin
      head       = 0;
      held       = 0;
      acc_x      = '0;
      acc_y      = '0;
      window_len = WINDOW_RESET;
      expected_totals_q.delete();
    end else begin
      // Compare a result beat with the oldest expectation
      if (result_bus.valid && result_bus.ready) begin
        if (expected_totals_q.size() == 0) begin
          err_total++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("%0t: result beat with nothing expected, actual %h %h %h", $time,
                     result_bus.window_sum_x, result_bus.window_sum_y,
                     result_bus.entry_count);
          end
        end else begin
          want = expected_totals_q.pop_front();
          check_field("window_sum_x", 32'(want.sum_x),
                      32'($unsigned(result_bus.window_sum_x)));
          check_field("window_sum_y", 32'(want.sum_y),
                      32'($unsigned(result_bus.window_sum_y)));
          check_field("entry_count", 32'(want.count), 32'(result_bus.entry_count));
        end
      end
      // Predict each accepted item beat
      if (item_bus.valid && item_bus.ready)
        expected_totals_q.push_back(next_window_totals(item_bus.op, item_bus.event_time,
                                                       item_bus.delta_x, item_bus.delta_y));
      // Track register writes, check register reads
      if (psel && penable && pready && paddr[2] == REG_WINDOW) begin
        if (pwrite) window_len = pwdata[WINDOW_W-1:0];
        else check_field("window_ns readback", 32'(window_len), 32'(prdata[WINDOW_W-1:0]));
      end
    end
    mismatch_count <= err_total;
    results_owed   <= expected_totals_q.size();
  end

endmodule

[tb/tb_time_window_motion_accumulator_unit.sv]
// Testbench top for the motion accumulator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_time_window_motion_accumulator_unit;
  import twma_pkg::*;

  localparam int          LIMIT_CYCLES  = 1000000;
  localparam int          LONG_HOLD     = 400;
  localparam int          LATENCY_SLACK = RING_DEPTH_DEF + 8;
  localparam logic [APB_AW-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE  = {~REG_WINDOW, 2'b00};
  localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                mismatch_count;
  int                results_owed;
  int unsigned       cycle_count = 0;

  int                sender_gap_pct = 0;
  int                receiver_stall_pct = 0;
  int                hold_requests = 0;
  logic [WINDOW_W-1:0] window_now = WINDOW_RESET;
  logic [TIME_W-1:0]   clock_ns = '0;

  twma_item_if   item_bus ();
  twma_result_if result_bus ();

  time_window_motion_accumulator_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  twma_window_checker sum_checker (
    .clk            (clk),
    .rst            (rst),
    .item_bus       (item_bus),
    .result_bus     (result_bus),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    int holds_served;
    holds_served = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_bus.ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        result_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Offer one item beat, idling at random first; valid stays high after the beat
  task automatic send_item(input logic op, input logic [TIME_W-1:0] t,
                           input logic signed [DELTA_W-1:0] dx,
                           input logic signed [DELTA_W-1:0] dy);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.op         <= op;
    item_bus.event_time <= t;
    item_bus.delta_x    <= dx;
    item_bus.delta_y    <= dy;
    do @(posedge clk); while (!item_bus.ready);
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic await_quiet();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [DELTA_W-1:0] pick_delta();
    case ($urandom_range(0, 7))
      0:       return DELTA_MAX;
      1:       return DELTA_MIN;
      2:       return DELTA_W'(int'($urandom_range(0, 32)) - 16);
      default: return DELTA_W'($urandom);
    endcase
  endfunction

  // Mostly time-ordered samples and ticks, with full-ring bursts, time jumps and noise
  task automatic run_motion_traffic(input int n_items, input int hold_at, input int pause_at);
    logic              op_sel;
    logic [TIME_W-1:0] t_sel;
    logic [TIME_W-1:0] span;
    int                roll;
    int                burst_left;
    burst_left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (k == hold_at) hold_requests++;
      if (k == pause_at) await_quiet();
      roll = $urandom_range(0, 99);
      if (burst_left == 0 && roll < 4) burst_left = $urandom_range(60, 80);
      if (burst_left > 0) begin
        // fill the ring without purging so it evicts
        burst_left--;
        clock_ns = clock_ns + TIME_W'($urandom_range(0, 1));
        op_sel   = OP_SAMPLE;
        t_sel    = clock_ns;
      end else if (roll < 12) begin
        op_sel = $urandom_range(0, 1) ? OP_TICK : OP_SAMPLE;
        t_sel  = {$urandom, $urandom};
      end else if (roll < 15) begin
        // jump the clock: anywhere, near the top, or near zero
        case ($urandom_range(0, 2))
          0:       clock_ns = {$urandom, $urandom};
          1:       clock_ns = TIME_MAX - TIME_W'($urandom_range(0, 100000));
          default: clock_ns = TIME_W'($urandom_range(0, 100000));
        endcase
        op_sel = OP_TICK;
        t_sel  = clock_ns;
      end else begin
        span = TIME_W'(window_now) / 16 + 2;
        if ($urandom_range(0, 19) == 0) clock_ns = clock_ns + 2 * TIME_W'(window_now) + 1;
        else clock_ns = clock_ns + ({$urandom, $urandom} % span);
        op_sel = ($urandom_range(0, 99) < 30) ? OP_TICK : OP_SAMPLE;
        t_sel  = clock_ns;
      end
      send_item(op_sel, t_sel, pick_delta(), pick_delta());
    end
  endtask

  initial begin
    rst                 = 1'b1;
    item_bus.valid      = 1'b0;
    item_bus.op         = OP_SAMPLE;
    item_bus.event_time = '0;
    item_bus.delta_x    = '0;
    item_bus.delta_y    = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window: directed corners first
    sender_gap_pct     = 14;
    receiver_stall_pct = 73;
    send_item(OP_TICK, '0, '0, '0);                    // tick on an empty ring
    send_item(OP_SAMPLE, '0, DELTA_MAX, DELTA_MIN);
    send_item(OP_SAMPLE, 64'd5, DELTA_MIN, DELTA_MAX);
    send_item(OP_SAMPLE, 64'd1000, -20'sd1, '0);
    send_item(OP_TICK, 64'd5000000, '0, '0);           // cutoff below zero
    send_item(OP_TICK, 64'(WINDOW_RESET), '0, '0);     // cutoff exactly zero
    send_item(OP_TICK, 64'(WINDOW_RESET) + 1, '0, '0); // pop the first sample
    send_item(OP_TICK, 64'(WINDOW_RESET) + 6, '0, '0);
    send_item(OP_TICK, TIME_MAX, DELTA_MAX, DELTA_MIN); // empty the ring, deltas ignored
    send_item(OP_SAMPLE, TIME_MAX, 20'sd1, -20'sd1);
    send_item(OP_SAMPLE, '0, DELTA_MAX, DELTA_MAX);
    send_item(OP_TICK, TIME_MAX, '0, '0);              // newest-in-front stops the purge
    send_item(OP_TICK, '0, DELTA_MIN, DELTA_MAX);
    send_item(OP_SAMPLE, 64'h8000_0000_0000_0000, DELTA_MIN, DELTA_MIN);
    send_item(OP_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF, DELTA_MAX, '0);
    send_item(OP_TICK, 64'h8000_0000_0000_0000 + 64'(WINDOW_RESET), '0, '0);
    send_item(OP_TICK, TIME_MAX, '0, '0);
    run_motion_traffic(450, -1, -1);
    await_quiet();

    // Narrowest window; touch the unused register slot too
    window_now = 32'd1;
    apb_access(1'b1, ADDR_WINDOW, APB_DW'(window_now));
    apb_access(1'b1, ADDR_SPARE, $urandom);
    apb_access(1'b0, ADDR_WINDOW, '0);
    sender_gap_pct     = 73;
    receiver_stall_pct = 14;
    clock_ns           = '0;
    run_motion_traffic(450, -1, 200);
    await_quiet();

    // Widest window, no idling, one long receiver hold-off
    window_now = '1;
    apb_access(1'b1, ADDR_WINDOW, APB_DW'(window_now));
    apb_access(1'b0, ADDR_WINDOW, '0);
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    run_motion_traffic(450, 150, -1);
    await_quiet();

    // Random mid-range window
    window_now = WINDOW_W'($urandom_range(1000, 50000000));
    apb_access(1'b1, ADDR_WINDOW, APB_DW'(window_now));
    apb_access(1'b0, ADDR_WINDOW, '0);
    run_motion_traffic(450, -1, -1);
    await_quiet();

    repeat (LATENCY_SLACK) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
